FILE: rtl/core/assert_macros.svh
// Assertion macros used by the RTL file that carries checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold outside reset
`define ASSERT_NEVER(label, rst, cond, msg) \
   label: assert property (@(posedge clock) disable iff (rst) !(cond)) \
      else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, rst, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/dlr_pkg.sv
// Shared constants, types and helpers for the DDA line rasterizer
package dlr_pkg;

   // Coordinate formats
   localparam int COORD_BITS    = 10;
   localparam int IN_FRAC_BITS  = 6;
   localparam int ACC_FRAC_BITS = 16;

   localparam int IN_BITS      = COORD_BITS + IN_FRAC_BITS;
   localparam int ACC_W        = COORD_BITS + ACC_FRAC_BITS + 2;
   localparam int INC_W        = ACC_FRAC_BITS + 2;
   localparam int QUO_W        = ACC_FRAC_BITS + 1;
   localparam int DIVIDEND_W   = COORD_BITS + ACC_FRAC_BITS;
   localparam int DIV_CNT_W    = $clog2(DIVIDEND_W + 1);
   localparam int PIX_W        = ACC_W - ACC_FRAC_BITS;
   localparam int LEFT_W       = COORD_BITS + 1;

   // Input to accumulator alignment
   localparam int ACC_LSH = (ACC_FRAC_BITS >= IN_FRAC_BITS) ? ACC_FRAC_BITS - IN_FRAC_BITS : 0;
   localparam int ACC_RSH = (ACC_FRAC_BITS >= IN_FRAC_BITS) ? 0 : IN_FRAC_BITS - ACC_FRAC_BITS;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((4 * IN_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

   // Configuration register map
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_X = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_Y = 1'b1;
   localparam logic [COORD_BITS-1:0] MAX_X_RESET = COORD_BITS'(799);
   localparam logic [COORD_BITS-1:0] MAX_Y_RESET = COORD_BITS'(599);

   // Request kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y
   } dlr_state_type;

   // Divider command and status
   typedef struct packed {
      logic                  start;
      logic [COORD_BITS-1:0] dividend_mag;
      logic [COORD_BITS-1:0] divisor;
   } dlr_div_cmd_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } dlr_div_status_type;

   // Convert an input coordinate to accumulator format
   function automatic logic [ACC_W-1:0] to_acc(input logic [IN_BITS-1:0] v);
      logic [ACC_W-1:0] ext;
      ext = ACC_W'(v);
      return (ext << ACC_LSH) >> ACC_RSH;
   endfunction

endpackage

FILE: rtl/core/dda_line_rasterizer.sv
// DDA line rasterizer top level: sequencer, accumulators and stream ports
//
// req channel: tuser is the kind (0 start a line, 1 next pixel); tdata carries
// start_x, start_y, end_x, end_y, each unsigned Q10.6, lowest bits first.
// A start transfer gives no result. It loads the accumulators, then runs the
// shared restoring divider twice (x increment, then y), one quotient bit a
// cycle: req_tready stays low after the start transfer until both divisions
// are done.
// A step transfer with an active line puts one pixel into the output register
// the cycle after the transfer; with the receiver taking every result, steps
// go at one per cycle (one accumulator add and round per pixel).
// rsp channel: tdata holds pixel_x then pixel_y; tlast marks the final pixel
// or an abort; tuser is the status (1 pixel outside the window, line aborted).
// A step with no active line is taken and dropped.
// When the receiver stalls, the result holds and req_tready drops until the
// output register frees up.
// csr port: index 0 max_x, index 1 max_y, written at any edge with csr_we outside reset.
// Synchronous reset clears the line, the sequencer and the output valid flag,
// and sets the window limits to max_x 799 and max_y 599.
`include "assert_macros.svh"

module dda_line_rasterizer (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dlr_pkg::REQ_DATA_W-1:0]      req_tdata,  // start_x, start_y, end_x, end_y
   input  logic                                req_tuser,  // kind
   // Result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dlr_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // pixel_x, pixel_y, zero pad
   output logic                                rsp_tlast,
   output logic                                rsp_tuser,  // status
   // Configuration writes
   input  logic                                csr_we,
   input  logic [dlr_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [dlr_pkg::COORD_BITS-1:0]      csr_wdata
);

   localparam int IB = dlr_pkg::IN_BITS;
   localparam int CB = dlr_pkg::COORD_BITS;

   dlr_pkg::dlr_state_type             state_ff, state_in;
   logic                               active_ff, active_in;
   logic [dlr_pkg::ACC_W-1:0]          acc_x_ff, acc_x_in;
   logic [dlr_pkg::ACC_W-1:0]          acc_y_ff, acc_y_in;
   logic [dlr_pkg::INC_W-1:0]          inc_x_ff, inc_x_in;
   logic [dlr_pkg::INC_W-1:0]          inc_y_ff, inc_y_in;
   logic [dlr_pkg::LEFT_W-1:0]         left_ff, left_in;
   logic [CB-1:0]                      mag_y_ff, mag_y_in;
   logic                               neg_x_ff, neg_x_in;
   logic                               neg_y_ff, neg_y_in;
   logic                               zero_ff, zero_in;
   logic [CB-1:0]                      max_x_ff, max_y_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]                      rsp_x_ff, rsp_x_in;
   logic [CB-1:0]                      rsp_y_ff, rsp_y_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic                               rsp_stat_ff, rsp_stat_in;

   logic [IB-1:0]                      sx, sy, ex, ey;
   logic [IB-1:0]                      dx, dy;
   logic                               nx, ny;
   logic [CB-1:0]                      mx, my, steps;
   logic                               accept;
   logic [dlr_pkg::ACC_W-1:0]          tx, ty;
   logic [dlr_pkg::PIX_W-1:0]          px, py;
   logic                               outside;
   logic [dlr_pkg::LEFT_W-1:0]         left_dec;
   logic [dlr_pkg::INC_W-1:0]          quo_ext;
   logic [dlr_pkg::INC_W-1:0]          inc_new;

   dlr_pkg::dlr_div_cmd_type           div_cmd;
   dlr_pkg::dlr_div_status_type        div_status;

   // Unpack the request payload
   assign sx = req_tdata[IB-1:0];
   assign sy = req_tdata[2*IB-1:IB];
   assign ex = req_tdata[3*IB-1:2*IB];
   assign ey = req_tdata[4*IB-1:3*IB];

   // Whole-pixel differences and step count
   assign nx    = ex < sx;
   assign ny    = ey < sy;
   assign dx    = nx ? sx - ex : ex - sx;
   assign dy    = ny ? sy - ey : ey - sy;
   assign mx    = dx[IB-1:dlr_pkg::IN_FRAC_BITS];
   assign my    = dy[IB-1:dlr_pkg::IN_FRAC_BITS];
   assign steps = (mx > my) ? mx : my;

   // Round half up: add one half, keep the whole part
   assign tx = acc_x_ff + dlr_pkg::ACC_W'(1 << (dlr_pkg::ACC_FRAC_BITS - 1));
   assign ty = acc_y_ff + dlr_pkg::ACC_W'(1 << (dlr_pkg::ACC_FRAC_BITS - 1));
   assign px = tx[dlr_pkg::ACC_W-1:dlr_pkg::ACC_FRAC_BITS];
   assign py = ty[dlr_pkg::ACC_W-1:dlr_pkg::ACC_FRAC_BITS];
   assign outside = px[dlr_pkg::PIX_W-1] || py[dlr_pkg::PIX_W-1] ||
                    (px[CB:0] > {1'b0, max_x_ff}) || (py[CB:0] > {1'b0, max_y_ff});
   assign left_dec = (left_ff != '0) ? left_ff - 1'b1 : left_ff;

   // Signed increment from the divider result
   assign quo_ext = dlr_pkg::INC_W'(div_status.quotient);

   // Accept only when idle and the output register can take a result
   assign req_tready = (state_ff == dlr_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // Sequencer, accumulators and output register
   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      inc_x_in     = inc_x_ff;
      inc_y_in     = inc_y_ff;
      left_in      = left_ff;
      mag_y_in     = mag_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_stat_in  = rsp_stat_ff;
      div_cmd      = '0;
      inc_new      = '0;
      case (state_ff)
         dlr_pkg::ST_IDLE: begin
            if (accept && req_tuser == dlr_pkg::KIND_START) begin
               acc_x_in  = dlr_pkg::to_acc(sx);
               acc_y_in  = dlr_pkg::to_acc(sy);
               left_in   = dlr_pkg::LEFT_W'(steps) + 1'b1;
               active_in = 1'b1;
               mag_y_in  = my;
               neg_x_in  = nx;
               neg_y_in  = ny;
               zero_in   = (steps == '0);
               div_cmd.start        = 1'b1;
               div_cmd.dividend_mag = mx;
               div_cmd.divisor      = steps;
               state_in  = dlr_pkg::ST_DIV_X;
            end else if (accept && active_ff) begin
               // Emit the pixel, then advance or end the line
               rsp_valid_in = 1'b1;
               rsp_x_in     = px[CB-1:0];
               rsp_y_in     = py[CB-1:0];
               rsp_stat_in  = outside;
               if (outside) begin
                  rsp_last_in = 1'b1;
                  active_in   = 1'b0;
               end else begin
                  acc_x_in    = acc_x_ff + {{(dlr_pkg::ACC_W-dlr_pkg::INC_W){inc_x_ff[dlr_pkg::INC_W-1]}},
                                            inc_x_ff};
                  acc_y_in    = acc_y_ff + {{(dlr_pkg::ACC_W-dlr_pkg::INC_W){inc_y_ff[dlr_pkg::INC_W-1]}},
                                            inc_y_ff};
                  left_in     = left_dec;
                  rsp_last_in = (left_dec == '0);
                  active_in   = (left_dec != '0);
               end
            end
         end
         dlr_pkg::ST_DIV_X: begin
            if (div_status.done) begin
               inc_new  = neg_x_ff ? -quo_ext : quo_ext;
               inc_x_in = zero_ff ? '0 : inc_new;
               div_cmd.start        = 1'b1;
               div_cmd.dividend_mag = mag_y_ff;
               div_cmd.divisor      = left_ff[CB-1:0] - 1'b1;
               state_in = dlr_pkg::ST_DIV_Y;
            end
         end
         dlr_pkg::ST_DIV_Y: begin
            if (div_status.done) begin
               inc_new  = neg_y_ff ? -quo_ext : quo_ext;
               inc_y_in = zero_ff ? '0 : inc_new;
               state_in = dlr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dlr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlr_pkg::ST_IDLE;
         active_ff    <= 1'b0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         inc_x_ff     <= '0;
         inc_y_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         acc_x_ff     <= acc_x_in;
         acc_y_ff     <= acc_y_in;
         inc_x_ff     <= inc_x_in;
         inc_y_ff     <= inc_y_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_y_ff    <= mag_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      zero_ff     <= zero_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   // Window limits
   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff <= dlr_pkg::MAX_X_RESET;
         max_y_ff <= dlr_pkg::MAX_Y_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            dlr_pkg::CSR_MAX_X: max_x_ff <= csr_wdata;
            dlr_pkg::CSR_MAX_Y: max_y_ff <= csr_wdata;
            default: begin
               max_x_ff <= max_x_ff;
            end
         endcase
      end
   end

   // Shared divider
   dlr_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .cmd    (div_cmd),
      .status (div_status)
   );

   // Result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(dlr_pkg::RSP_DATA_W-2*CB){1'b0}}, rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_stat_ff;

   // Checks
   `ASSERT_NEVER(a_ready_only_idle, reset, req_tready && (state_ff != dlr_pkg::ST_IDLE), "ready outside idle")
   `ASSERT_NEXT(a_start_divides, reset, accept && (req_tuser == dlr_pkg::KIND_START), state_ff == dlr_pkg::ST_DIV_X, "start did not enter division")
   `ASSERT_IMPLIES(a_done_in_div, reset, div_status.done, state_ff != dlr_pkg::ST_IDLE, "divider done while idle")
   `ASSERT_NEXT(a_no_line_no_pixel, reset, accept && (req_tuser == dlr_pkg::KIND_STEP) && !active_ff && !(rsp_valid_ff && !rsp_tready), !rsp_valid_ff, "pixel without a line")

endmodule

FILE: rtl/core/dlr_divider.sv
// Restoring divider: one quotient bit a cycle, (mag << ACC_FRAC_BITS) / divisor
module dlr_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  dlr_pkg::dlr_div_cmd_type    cmd,
   output dlr_pkg::dlr_div_status_type status
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [dlr_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [dlr_pkg::COORD_BITS-1:0]    rem_ff, rem_in;
   logic [dlr_pkg::DIVIDEND_W-1:0]    quo_ff, quo_in;
   logic [dlr_pkg::COORD_BITS-1:0]    div_ff, div_in;
   logic [dlr_pkg::COORD_BITS:0]      trial;
   logic [dlr_pkg::COORD_BITS:0]      diff;
   logic                              fits;

   // Trial subtract of the shifted remainder
   assign trial = {rem_ff, quo_ff[dlr_pkg::DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   // Load, iterate and finish
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = {cmd.dividend_mag, {dlr_pkg::ACC_FRAC_BITS{1'b0}}};
         div_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[dlr_pkg::COORD_BITS-1:0] : trial[dlr_pkg::COORD_BITS-1:0];
         quo_in = {quo_ff[dlr_pkg::DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == dlr_pkg::DIV_CNT_W'(dlr_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   // Quotient <= one whole unit if divisor != 0; the low bits hold it all
   assign status.done     = done_ff;
   assign status.quotient = quo_ff[dlr_pkg::QUO_W-1:0];

endmodule
